// ===== design/pdce_pkg.sv =====
// ----------------------------------------------------------------------------
// pdce_pkg
// Shared types, constants and helpers for the polyline delta character
// encoder.
// ----------------------------------------------------------------------------
package pdce_pkg;

  localparam int LAT_W   = 25;
  localparam int LNG_W   = 26;
  localparam int LVL_W   = 9;
  localparam int LATF_W  = LAT_W + 1;   // folded latitude delta
  localparam int LNGF_W  = LNG_W + 1;   // folded longitude delta
  localparam int VAL_W   = LNGF_W;      // widest number to chunk
  localparam int IDX_W   = 3;           // chunk index, 0..5
  localparam int CHAR_W  = 7;

  localparam logic [LVL_W-1:0] DROP_LEVEL = 9'h1FF;
  localparam logic [5:0]       CONT_BIT   = 6'h20;
  localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd63;

  // which number of the point is being emitted
  typedef enum logic [1:0] {
    PH_LVL,
    PH_LAT,
    PH_LNG
  } pdce_phase_t;

  // one kept point, ready for character emission
  typedef struct packed {
    logic [LVL_W-1:0]  lvl;
    logic [LATF_W-1:0] lat_f;
    logic [LNGF_W-1:0] lng_f;
    logic [IDX_W-1:0]  lvl_last;
    logic [IDX_W-1:0]  lat_last;
    logic [IDX_W-1:0]  lng_last;
  } pdce_job_t;

  // index of the highest nonzero 5-bit chunk (0 for a zero value)
  function automatic logic [IDX_W-1:0] last_chunk(input logic [VAL_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v[26:25] != 2'b0)      r = 3'd5;
    else if (v[24:20] != 5'b0) r = 3'd4;
    else if (v[19:15] != 5'b0) r = 3'd3;
    else if (v[14:10] != 5'b0) r = 3'd2;
    else if (v[9:5] != 5'b0)   r = 3'd1;
    else                       r = 3'd0;
    return r;
  endfunction

  // 5-bit chunk number idx, lowest chunk first
  function automatic logic [4:0] chunk(input logic [VAL_W-1:0] v,
                                       input logic [IDX_W-1:0] idx);
    logic [29:0] p;
    logic [4:0]  r;
    p = {3'b0, v};
    case (idx)
      3'd0:    r = p[4:0];
      3'd1:    r = p[9:5];
      3'd2:    r = p[14:10];
      3'd3:    r = p[19:15];
      3'd4:    r = p[24:20];
      3'd5:    r = p[29:25];
      default: r = 5'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/polyline_delta_char_encoder.sv =====
// ----------------------------------------------------------------------------
// polyline_delta_char_encoder
// Encoded polyline character encoder: one point in, level and delta
// characters out.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser        tlast
//  s_axis    in   lat_e5[24:0] lng_e5[50:25] lvl[59:51]   -            -
//  m_axis    out  out_char[6:0]                           stream_sel   last_char
//
// A kept point yields 3 to 14 characters, one per cycle from the character
// sequencer while the output is not stalled.
// A dropped point (level -1) is taken and yields nothing.
// The next point is taken while the current one is still being emitted.
// Reset clears the kept point to zero and empties both stages.
// A stalled output holds its character; the sequencer waits with it.
//
module polyline_delta_char_encoder import pdce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // lat_e5[24:0], lng_e5[50:25], zoom_level[59:51]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_char[6:0]
  output logic [0:0]  m_tuser,   // stream_sel[0]
  output logic        m_tlast
);

  logic              job_valid;
  pdce_job_t         job;
  logic              job_take;
  logic [CHAR_W-1:0] out_char;

  pdce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .lat_e5     (s_tdata[24:0]),
    .lng_e5     (s_tdata[50:25]),
    .zoom_level (s_tdata[59:51]),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take)
  );

  pdce_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (out_char),
    .stream_sel (m_tuser[0]),
    .last_char  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

// ===== design/pdce_front.sv =====
// ----------------------------------------------------------------------------
// pdce_front
// Input stage: drops points with the drop level, forms and zigzag-folds the
// deltas against the last kept point and holds the result as one job.
// ----------------------------------------------------------------------------
module pdce_front import pdce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LAT_W-1:0]  lat_e5,
  input  logic [LNG_W-1:0]  lng_e5,
  input  logic [LVL_W-1:0]  zoom_level,
  output logic              job_valid,
  output pdce_job_t         job,
  input  logic              job_take
);

  logic [LAT_W-1:0]  prev_lat;
  logic [LNG_W-1:0]  prev_lng;
  logic [LAT_W:0]    dlat;
  logic [LNG_W:0]    dlng;
  logic [LATF_W-1:0] lat_f;
  logic [LNGF_W-1:0] lng_f;
  logic              accept;
  logic              keep;
  pdce_job_t         job_next;

  assign in_ready = !job_valid || job_take;
  assign accept   = in_valid && in_ready;
  assign keep     = (zoom_level != DROP_LEVEL);

  // exact deltas, one bit wider than the coordinates
  assign dlat = {lat_e5[LAT_W-1], lat_e5} - {prev_lat[LAT_W-1], prev_lat};
  assign dlng = {lng_e5[LNG_W-1], lng_e5} - {prev_lng[LNG_W-1], prev_lng};

  // zigzag fold: shift left, invert when negative
  assign lat_f = {dlat[LAT_W-1:0], 1'b0} ^ {LATF_W{dlat[LAT_W]}};
  assign lng_f = {dlng[LNG_W-1:0], 1'b0} ^ {LNGF_W{dlng[LNG_W]}};

  // job contents with chunk counts
  always_comb begin
    job_next.lvl      = zoom_level;
    job_next.lat_f    = lat_f;
    job_next.lng_f    = lng_f;
    job_next.lvl_last = last_chunk({{(VAL_W-LVL_W){1'b0}}, zoom_level});
    job_next.lat_last = last_chunk({{(VAL_W-LATF_W){1'b0}}, lat_f});
    job_next.lng_last = last_chunk(lng_f);
  end

  // job register and kept point
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      prev_lat  <= '0;
      prev_lng  <= '0;
    end else begin
      if (accept && keep) begin
        job_valid <= 1'b1;
        prev_lat  <= lat_e5;
        prev_lng  <= lng_e5;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      job <= job_next;
    end
  end

endmodule

// ===== design/pdce_serial.sv =====
// ----------------------------------------------------------------------------
// pdce_serial
// Character sequencer: walks level, latitude and longitude chunk by chunk
// and drives the registered output character, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module pdce_serial import pdce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  pdce_job_t         job,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              stream_sel,
  output logic              last_char
);

  pdce_phase_t       phase, phase_next;
  logic              busy, busy_next;
  logic [IDX_W-1:0]  idx, idx_next;
  pdce_job_t         cur;
  logic              load;
  logic              adv;
  logic              num_last;
  logic              pt_last;
  logic [VAL_W-1:0]  val;
  logic [IDX_W-1:0]  val_last;
  logic [5:0]        code;
  logic [CHAR_W-1:0] ch;

  assign adv = !out_valid || out_ready;

  // number being emitted and its last chunk
  always_comb begin
    case (phase)
      PH_LVL: begin
        val      = {{(VAL_W-LVL_W){1'b0}}, cur.lvl};
        val_last = cur.lvl_last;
      end
      PH_LAT: begin
        val      = {{(VAL_W-LATF_W){1'b0}}, cur.lat_f};
        val_last = cur.lat_last;
      end
      PH_LNG: begin
        val      = cur.lng_f;
        val_last = cur.lng_last;
      end
      default: begin
        val      = '0;
        val_last = '0;
      end
    endcase
  end

  assign num_last = (idx == val_last);
  assign pt_last  = busy && (phase == PH_LNG) && num_last;
  assign job_take = adv && (!busy || pt_last);
  assign load     = job_take && job_valid;

  // character: continuation bit on all but the last chunk, then bias
  assign code = (num_last ? 6'h00 : CONT_BIT) | {1'b0, chunk(val, idx)};
  assign ch   = {1'b0, code} + CHAR_BIAS;

  // sequencer next state
  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    busy_next  = busy;
    if (adv) begin
      if (busy && !num_last) begin
        idx_next = idx + 3'd1;
      end else if (busy && (phase != PH_LNG)) begin
        idx_next   = '0;
        phase_next = (phase == PH_LVL) ? PH_LAT : PH_LNG;
      end else begin
        busy_next  = job_valid;
        idx_next   = '0;
        phase_next = PH_LVL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_LVL;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy  <= busy_next;
      phase <= phase_next;
      idx   <= idx_next;
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  // working copy of the job and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end
    if (adv && busy) begin
      out_char   <= ch;
      stream_sel <= (phase == PH_LVL);
      last_char  <= pt_last;
    end
  end

endmodule

// ===== design/pdce_checker.sv =====
// ----------------------------------------------------------------------------
// pdce_checker
// Port-level checks on the encoder output channel.
// ----------------------------------------------------------------------------
module pdce_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser,
  input logic       m_tlast
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  // characters stay printable
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7] == 1'b0 && m_tdata[6:0] >= 7'd63 && m_tdata[6:0] <= 7'd126)
    else $error("character out of range");

  // point end is a final longitude chunk on the point stream
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] == 1'b0 && m_tdata[6:0] < 7'd95)
    else $error("last character malformed");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind polyline_delta_char_encoder pdce_checker u_pdce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== verif/tb_polyline_delta_char_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_delta_char_encoder
// Self-checking bench for the encoded polyline character encoder. A directed
// table covers reset state, dropped points, level extremes and the widest
// deltas, then random points are sent: mostly short walks from the last kept
// point, plus full-range jumps and drops. Each point is run through a local
// encoder model and every output character is checked in order, under random
// idle bursts on both the input and the output side.
// ----------------------------------------------------------------------------
module tb_polyline_delta_char_encoder;
  import pdce_pkg::*;

  localparam int  NUM_DIRECTED  = 20;
  localparam int  NUM_RANDOM    = 480;
  localparam int  LIMIT_CYCLES  = 400000;
  localparam int  DRAIN_CYCLES  = 40;
  localparam logic SEL_POINT    = 1'b0;
  localparam logic SEL_LEVEL    = 1'b1;

  localparam logic [LAT_W-1:0] LAT_MAXV = 25'h0FFFFFF;
  localparam logic [LAT_W-1:0] LAT_MINV = 25'h1000000;
  localparam logic [LNG_W-1:0] LNG_MAXV = 26'h1FFFFFF;
  localparam logic [LNG_W-1:0] LNG_MINV = 26'h2000000;

  // one output character
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              sel;
    logic              last;
  } enc_char_t;

  // one input point, with an optional hand-written expectation
  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LNG_W-1:0] lng;
    logic [LVL_W-1:0] lvl;
    logic             typed;
    logic [1:0]       n_chars;
    enc_char_t [2:0]  chars;
  } point_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  // encoder model state
  longint      kept_lat = 0;
  longint      kept_lng = 0;
  enc_char_t   point_chars[$];
  enc_char_t   expected_chars[$];
  point_row_t  queued_points[$];
  point_row_t  directed_points [NUM_DIRECTED];

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          fail_count = 0;
  int          points_taken = 0;
  int          points_dropped = 0;
  int          chars_checked = 0;
  int          most_chars = 0;
  int          cycle_cnt = 0;

  polyline_delta_char_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // zigzag fold of a signed delta
  function automatic longint unsigned zigzag(input longint d);
    if (d < 0) return longint'(-d) * 2 - 1;
    return longint'(d) * 2;
  endfunction

  // split a number into 5-bit chunks, low chunk first, with continuation bit
  function automatic void emit_number(input longint unsigned n, input logic sel);
    enc_char_t c;
    c.sel  = sel;
    c.last = 1'b0;
    while (n >= 64'd32) begin
      c.ch = CHAR_W'(int'(n & 64'h1f) + int'(CONT_BIT) + int'(CHAR_BIAS));
      point_chars = {point_chars, c};
      n = n >> 5;
    end
    c.ch = CHAR_W'(int'(n) + int'(CHAR_BIAS));
    point_chars = {point_chars, c};
  endfunction

  // characters of one point; updates the kept point unless it is dropped
  function automatic void encode_point(input logic [63:0] d);
    logic [LVL_W-1:0] lvl;
    longint           lat_v;
    longint           lng_v;
    lvl = d[59:51];
    point_chars.delete();
    if (lvl == DROP_LEVEL) return;
    lat_v = longint'($signed(d[24:0]));
    lng_v = longint'($signed(d[50:25]));
    emit_number(longint'(lvl), SEL_LEVEL);
    emit_number(zigzag(lat_v - kept_lat), SEL_POINT);
    emit_number(zigzag(lng_v - kept_lng), SEL_POINT);
    point_chars[point_chars.size()-1].last = 1'b1;
    kept_lat = lat_v;
    kept_lng = lng_v;
  endfunction

  function automatic point_row_t plain_point(input logic [LAT_W-1:0] lat,
                                             input logic [LNG_W-1:0] lng,
                                             input logic [LVL_W-1:0] lvl);
    point_row_t r;
    r     = '0;
    r.lat = lat;
    r.lng = lng;
    r.lvl = lvl;
    return r;
  endfunction

  // zero delta from the kept point: level char then two bias chars
  function automatic point_row_t flat_point(input logic [LAT_W-1:0] lat,
                                            input logic [LNG_W-1:0] lng,
                                            input logic [LVL_W-1:0] lvl);
    point_row_t r;
    r          = plain_point(lat, lng, lvl);
    r.typed    = 1'b1;
    r.n_chars  = 2'd3;
    r.chars[0] = '{ch: CHAR_W'(lvl) + CHAR_BIAS, sel: SEL_LEVEL, last: 1'b0};
    r.chars[1] = '{ch: CHAR_BIAS, sel: SEL_POINT, last: 1'b0};
    r.chars[2] = '{ch: CHAR_BIAS, sel: SEL_POINT, last: 1'b1};
    return r;
  endfunction

  // a dropped point must give nothing
  function automatic point_row_t dropped_point(input logic [LAT_W-1:0] lat,
                                               input logic [LNG_W-1:0] lng);
    point_row_t r;
    r       = plain_point(lat, lng, DROP_LEVEL);
    r.typed = 1'b1;
    return r;
  endfunction

  // present one point and hold it until the transaction completes
  task automatic send_point(input point_row_t r);
    queued_points = {queued_points, r};
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, r.lvl, r.lng, r.lat};
    do @(posedge clk); while (!s_tready);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // output side backpressure
  initial begin
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // input and output monitor, one process so same-edge order is fixed
  always @(posedge clk) begin
    point_row_t cur;
    enc_char_t  exp_c;
    if (!rst) begin
      // accepted point: queue its expected characters
      if (s_tvalid && s_tready) begin
        cur = queued_points.pop_front();
        encode_point(s_tdata);
        points_taken++;
        if (point_chars.size() == 0) points_dropped++;
        if (point_chars.size() > most_chars) most_chars = point_chars.size();
        if (cur.typed) begin
          for (int i = 0; i < int'(cur.n_chars); i++)
            expected_chars = {expected_chars, cur.chars[i]};
        end else begin
          foreach (point_chars[i]) expected_chars = {expected_chars, point_chars[i]};
        end
      end
      // accepted character: compare with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: out_char %0d stream_sel %0d last_char %0d",
                 m_tdata, m_tuser[0], m_tlast);
          fail_count++;
        end else begin
          exp_c = expected_chars.pop_front();
          chars_checked++;
          if (m_tdata !== {1'b0, exp_c.ch}) begin
            $error("out_char: expected %0d, got %0d", exp_c.ch, m_tdata);
            fail_count++;
          end
          if (m_tuser[0] !== exp_c.sel) begin
            $error("stream_sel: expected %0d, got %0d", exp_c.sel, m_tuser[0]);
            fail_count++;
          end
          if (m_tlast !== exp_c.last) begin
            $error("last_char: expected %0d, got %0d", exp_c.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [LAT_W-1:0] walk_lat;
    logic [LNG_W-1:0] walk_lng;
    logic [LVL_W-1:0] lvl;
    point_row_t       r;
    longint           dl;
    int               kind;
    int               kept_rand;
    bit               paused;

    walk_lat  = '0;
    walk_lng  = '0;
    kept_rand = 0;
    paused    = 1'b0;

    directed_points[0]  = flat_point('0, '0, 9'd0);
    directed_points[1]  = dropped_point(25'd123, 26'd456);
    directed_points[2]  = dropped_point(LAT_MINV, LNG_MINV);
    directed_points[3]  = flat_point('0, '0, 9'd31);
    directed_points[4]  = plain_point(25'd1, 26'(-1), 9'd32);
    directed_points[5]  = plain_point(LAT_MAXV, LNG_MAXV, 9'd32);
    directed_points[6]  = plain_point(LAT_MINV, LNG_MINV, 9'd255);
    directed_points[7]  = plain_point(LAT_MAXV, LNG_MAXV, 9'h1FE);
    directed_points[8]  = plain_point(LAT_MAXV, LNG_MAXV, 9'h100);
    directed_points[9]  = flat_point(LAT_MAXV, LNG_MAXV, 9'd0);
    directed_points[10] = plain_point(25'(9000000), 26'(18000000), 9'd5);
    directed_points[11] = plain_point(25'(-9000000), 26'(-18000000), 9'd17);
    directed_points[12] = dropped_point('0, '0);
    directed_points[13] = plain_point(25'(-8999984), 26'(-18000016), 9'd1);
    directed_points[14] = plain_point('0, '0, 9'd100);
    directed_points[15] = plain_point(25'h0AAAAAA, 26'h1555555, 9'h0AA);
    directed_points[16] = plain_point(25'h1555555, 26'h2AAAAAA, 9'h155);
    directed_points[17] = dropped_point(LAT_MAXV, LNG_MAXV);
    directed_points[18] = plain_point(25'(-1), 26'(-1), 9'h0FF);
    directed_points[19] = plain_point('0, '0, 9'h1FE);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) send_point(directed_points[i]);

    // random points; walk from the last kept point of the directed part
    walk_lat = '0;
    walk_lng = '0;
    while (kept_rand < NUM_RANDOM) begin
      tx_idle_on = (kept_rand < 200 || kept_rand >= 260) && kept_rand < 420;
      rx_idle_on = tx_idle_on;

      // hold the input until the encoder has drained
      if (kept_rand == 300 && !paused) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0 || queued_points.size() != 0) @(posedge clk);
      end

      kind = $urandom_range(0, 9);
      if (kind < 6) lvl = 9'($urandom_range(0, 17));
      else if (kind < 8) lvl = 9'($urandom_range(18, 255));
      else lvl = 9'($urandom_range(256, 510));

      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // dropped point with arbitrary coordinates
        send_point(plain_point(25'($urandom), 26'($urandom), DROP_LEVEL));
      end else begin
        if (kind < 20) begin
          r = plain_point(25'($urandom), 26'($urandom), lvl);
        end else if (kind < 35) begin
          r = plain_point(25'(int'($urandom_range(0, 18000000)) - 9000000),
                          26'(int'($urandom_range(0, 36000000)) - 18000000), lvl);
        end else begin
          r = plain_point(walk_lat, walk_lng, lvl);
          dl = longint'($urandom & ((32'd1 << $urandom_range(0, 22)) - 1));
          if ($urandom_range(0, 1) == 1) dl = -dl;
          r.lat = walk_lat + 25'(dl);
          dl = longint'($urandom & ((32'd1 << $urandom_range(0, 22)) - 1));
          if ($urandom_range(0, 1) == 1) dl = -dl;
          r.lng = walk_lng + 26'(dl);
        end
        walk_lat = r.lat;
        walk_lng = r.lng;
        send_point(r);
        kept_rand++;
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (expected_chars.size() != 0 || queued_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d points taken, %0d dropped, %0d characters checked",
             points_taken, points_dropped, chars_checked);
    $display("summary: up to %0d characters per point, %0d mismatches",
             most_chars, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
